FILE: design/lpec_pkg.sv
// Shared types, codes and constants for the light panel event controller.
// Used by lpec_update and light_panel_event_controller; depends on nothing.
package lpec_pkg;

    // Switch count and mask
    localparam int SWITCH_COUNT = 6;
    localparam int SWITCH_W     = 6;
    localparam logic [SWITCH_W-1:0] ALL_SWITCHES = SWITCH_W'((1 << SWITCH_COUNT) - 1);

    // Action codes
    localparam logic [3:0] ACT_BUTTON  = 4'd0;
    localparam logic [3:0] ACT_CW      = 4'd1;
    localparam logic [3:0] ACT_CCW     = 4'd2;
    localparam logic [3:0] ACT_SWITCH  = 4'd3;
    localparam logic [3:0] ACT_ONOFF   = 4'd4;
    localparam logic [3:0] ACT_BRIGHT  = 4'd5;
    localparam logic [3:0] ACT_TEMP    = 4'd6;
    localparam logic [3:0] ACT_RS232   = 4'd7;
    localparam logic [3:0] ACT_OTA     = 4'd8;

    // Special buttons
    localparam logic [7:0] BUTTON_ALL  = 8'd7;
    localparam logic [7:0] BUTTON_MODE = 8'd8;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BHIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TLOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VFAST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM = 3'd6;
    localparam int CFG_DATA_W = 16;

    // Configuration reset values
    localparam logic [7:0]  RST_BLOW   = 8'd1;
    localparam logic [7:0]  RST_BHIGH  = 8'd100;
    localparam logic [15:0] RST_TLOW   = 16'd2700;
    localparam logic [15:0] RST_THIGH  = 16'd6500;
    localparam logic [15:0] RST_VFAST  = 16'd60;
    localparam logic [15:0] RST_FAST   = 16'd130;
    localparam logic [15:0] RST_MEDIUM = 16'd300;

    // Detent speed classes
    typedef enum logic [1:0] {
        SPD_SLOW  = 2'd0,
        SPD_MED   = 2'd1,
        SPD_FAST  = 2'd2,
        SPD_VFAST = 2'd3
    } t_speed;

    typedef struct packed {
        logic [3:0]  action;
        logic [7:0]  target;
        logic [15:0] value;
        logic [31:0] tick;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  switch_mask;
        logic        light_on;
        logic [7:0]  brightness_now;
        logic [15:0] temp_now;
        logic        serial_enabled;
        logic        update_enabled;
        logic        temp_mode;
        logic        changed;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  blow;
        logic [7:0]  bhigh;
        logic [15:0] tlow;
        logic [15:0] thigh;
        logic [15:0] vfast;
        logic [15:0] fast;
        logic [15:0] mid;
    } t_cfg;

    typedef struct packed {
        logic [SWITCH_W-1:0] switches_on;
        logic [SWITCH_W-1:0] last_active;
        logic [7:0]          brightness;
        logic [15:0]         temperature;
        logic                serial_flag;
        logic                update_flag;
        logic                mode_flag;
        logic [31:0]         last_tick;
    } t_state;

    // Brightness step per speed class
    function automatic logic [3:0] bright_step(t_speed spd);
        logic [3:0] s;
        unique case (spd)
            SPD_VFAST: s = 4'd10;
            SPD_FAST:  s = 4'd5;
            SPD_MED:   s = 4'd2;
            default:   s = 4'd1;
        endcase
        return s;
    endfunction

    // Temperature step per speed class
    function automatic logic [8:0] temp_step(t_speed spd);
        logic [8:0] s;
        unique case (spd)
            SPD_VFAST: s = 9'd500;
            SPD_FAST:  s = 9'd300;
            SPD_MED:   s = 9'd200;
            default:   s = 9'd100;
        endcase
        return s;
    endfunction

endpackage

FILE: design/light_panel_event_controller.sv
// Top level of the light panel event controller: handshakes, configuration and state.
// Depends on lpec_pkg and lpec_update.

// One event enters per clock cycle while the event side is not stalled:
// the event is captured in an input register, applied to the panel state
// by a single stage of compare, add and clamp logic, and the full state
// with a changed flag is held in an output register until taken. The
// state feeds back within that stage, so back-to-back events see each
// other's effects. A stall on the result side holds both registers and,
// once the input register is also occupied, stalls the event side.
// Configuration writes take effect at once and do not move the stored
// brightness or temperature.
module light_panel_event_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  lpec_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output lpec_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [lpec_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lpec_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic                r_in_vld;
    lpec_pkg::t_in_item  r_in;
    logic                r_out_vld;
    lpec_pkg::t_out_item r_out;
    lpec_pkg::t_cfg      r_cfg;
    lpec_pkg::t_state    r_state;
    lpec_pkg::t_state    n_state;
    logic                n_changed;
    logic                advance;
    logic                in_take;

    // Move the input register forward when the output register can take it
    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // Hold the input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!r_in_vld || advance) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blow   <= lpec_pkg::RST_BLOW;
            r_cfg.bhigh  <= lpec_pkg::RST_BHIGH;
            r_cfg.tlow   <= lpec_pkg::RST_TLOW;
            r_cfg.thigh  <= lpec_pkg::RST_THIGH;
            r_cfg.vfast  <= lpec_pkg::RST_VFAST;
            r_cfg.fast   <= lpec_pkg::RST_FAST;
            r_cfg.mid    <= lpec_pkg::RST_MEDIUM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lpec_pkg::CFG_BLOW:   r_cfg.blow   <= i_cfg_data[7:0];
                lpec_pkg::CFG_BHIGH:  r_cfg.bhigh  <= i_cfg_data[7:0];
                lpec_pkg::CFG_TLOW:   r_cfg.tlow   <= i_cfg_data;
                lpec_pkg::CFG_THIGH:  r_cfg.thigh  <= i_cfg_data;
                lpec_pkg::CFG_VFAST:  r_cfg.vfast  <= i_cfg_data;
                lpec_pkg::CFG_FAST:   r_cfg.fast   <= i_cfg_data;
                lpec_pkg::CFG_MEDIUM: r_cfg.mid    <= i_cfg_data;
                default:              r_cfg        <= r_cfg;
            endcase
        end
    end

    // Event logic
    lpec_update u_update (
        .i_state   (r_state),
        .i_evt     (r_in),
        .i_cfg     (r_cfg),
        .o_state   (n_state),
        .o_changed (n_changed)
    );

    // Commit panel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.switches_on <= '0;
            r_state.last_active <= lpec_pkg::ALL_SWITCHES;
            r_state.brightness  <= lpec_pkg::RST_BHIGH;
            r_state.temperature <= lpec_pkg::RST_TLOW;
            r_state.serial_flag <= 1'b0;
            r_state.update_flag <= 1'b0;
            r_state.mode_flag   <= 1'b0;
            r_state.last_tick   <= 32'd0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.switch_mask    <= n_state.switches_on;
            r_out.light_on       <= (n_state.switches_on != '0);
            r_out.brightness_now <= n_state.brightness;
            r_out.temp_now       <= n_state.temperature;
            r_out.serial_enabled <= n_state.serial_flag;
            r_out.update_enabled <= n_state.update_flag;
            r_out.temp_mode      <= n_state.mode_flag;
            r_out.changed        <= n_changed;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // State moves only when a transaction is applied
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("panel state changed without a transaction");

    // Switches, levels and the serial and update flags stay put when the result says nothing changed
    a_quiet_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !n_changed) |=> ($stable(r_state.switches_on) &&
            $stable(r_state.brightness) && $stable(r_state.temperature) &&
            $stable(r_state.serial_flag) && $stable(r_state.update_flag)))
        else $error("state changed but changed flag is low");

    // Saved mask is never empty
    a_last_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.last_active != '0)
        else $error("saved switch mask is empty");

    // Result agrees with the state it reports
    a_out_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(advance) |-> (r_out.switch_mask == r_state.switches_on &&
            r_out.light_on == (r_state.switches_on != '0)))
        else $error("result does not match committed state");

endmodule

FILE: design/lpec_update.sv
// Next-state logic of the light panel event controller: one event against the state.
// Depends on lpec_pkg.
module lpec_update (
    input  lpec_pkg::t_state   i_state,
    input  lpec_pkg::t_in_item i_evt,
    input  lpec_pkg::t_cfg     i_cfg,
    output lpec_pkg::t_state   o_state,
    output logic               o_changed
);

    logic                          id_ok;
    logic [lpec_pkg::SWITCH_W-1:0] id_bit;
    logic [lpec_pkg::SWITCH_W-1:0] restore_mask;
    logic [31:0]                   elapsed;
    lpec_pkg::t_speed              speed;
    logic signed [9:0]             bri_cand;
    logic [7:0]                    bri_clamped;
    logic signed [17:0]            tmp_cand;
    logic [15:0]                   tmp_clamped;
    logic [lpec_pkg::SWITCH_W-1:0] mask_req;
    logic                          mask_do;
    logic                          is_detent;

    // Decode switch number
    assign id_ok  = (i_evt.target != 8'd0) &&
                    (i_evt.target <= 8'(lpec_pkg::SWITCH_COUNT));
    assign id_bit = lpec_pkg::SWITCH_W'(1) << (i_evt.target[2:0] - 3'd1);

    // Restore falls back to all switches when nothing was saved
    assign restore_mask = (i_state.last_active == '0) ? lpec_pkg::ALL_SWITCHES
                                                      : i_state.last_active;

    // Classify detent speed from modular elapsed ticks
    assign elapsed = i_evt.tick - i_state.last_tick;
    always_comb begin
        priority if (elapsed <= {16'd0, i_cfg.vfast}) begin
            speed = lpec_pkg::SPD_VFAST;
        end else if (elapsed <= {16'd0, i_cfg.fast}) begin
            speed = lpec_pkg::SPD_FAST;
        end else if (elapsed <= {16'd0, i_cfg.mid}) begin
            speed = lpec_pkg::SPD_MED;
        end else begin
            speed = lpec_pkg::SPD_SLOW;
        end
    end

    assign is_detent = (i_evt.action == lpec_pkg::ACT_CW) ||
                       (i_evt.action == lpec_pkg::ACT_CCW);

    // Candidate brightness: stepped level on a detent, else the set value
    always_comb begin
        if (!is_detent) begin
            bri_cand = $signed({2'b00, i_evt.value[7:0]});
        end else if (i_evt.action == lpec_pkg::ACT_CW) begin
            bri_cand = $signed({2'b00, i_state.brightness})
                     + $signed({6'd0, lpec_pkg::bright_step(speed)});
        end else begin
            bri_cand = $signed({2'b00, i_state.brightness})
                     - $signed({6'd0, lpec_pkg::bright_step(speed)});
        end
    end

    // Candidate temperature
    always_comb begin
        if (!is_detent) begin
            tmp_cand = $signed({2'b00, i_evt.value});
        end else if (i_evt.action == lpec_pkg::ACT_CW) begin
            tmp_cand = $signed({2'b00, i_state.temperature})
                     + $signed({9'd0, lpec_pkg::temp_step(speed)});
        end else begin
            tmp_cand = $signed({2'b00, i_state.temperature})
                     - $signed({9'd0, lpec_pkg::temp_step(speed)});
        end
    end

    // Clamp: the low bound is checked first; when the bounds cross, a value below it gets the low bound, else the high
    always_comb begin
        priority if (bri_cand < $signed({2'b00, i_cfg.blow})) begin
            bri_clamped = i_cfg.blow;
        end else if (bri_cand > $signed({2'b00, i_cfg.bhigh})) begin
            bri_clamped = i_cfg.bhigh;
        end else begin
            bri_clamped = bri_cand[7:0];
        end
    end

    always_comb begin
        priority if (tmp_cand < $signed({2'b00, i_cfg.tlow})) begin
            tmp_clamped = i_cfg.tlow;
        end else if (tmp_cand > $signed({2'b00, i_cfg.thigh})) begin
            tmp_clamped = i_cfg.thigh;
        end else begin
            tmp_clamped = tmp_cand[15:0];
        end
    end

    // Apply the event
    always_comb begin
        o_state   = i_state;
        o_changed = 1'b0;
        mask_req  = i_state.switches_on;
        mask_do   = 1'b0;

        unique case (i_evt.action)
            lpec_pkg::ACT_BUTTON: begin
                priority if (id_ok) begin
                    mask_req = i_state.switches_on ^ id_bit;
                    mask_do  = 1'b1;
                end else if (i_evt.target == lpec_pkg::BUTTON_ALL) begin
                    if (i_state.switches_on != '0) begin
                        o_state.last_active = i_state.switches_on;
                        mask_req            = '0;
                    end else begin
                        mask_req = restore_mask;
                    end
                    mask_do = 1'b1;
                end else if (i_evt.target == lpec_pkg::BUTTON_MODE) begin
                    o_state.mode_flag = ~i_state.mode_flag;
                end else begin
                    o_state.mode_flag = i_state.mode_flag;
                end
            end
            lpec_pkg::ACT_CW, lpec_pkg::ACT_CCW: begin
                o_state.last_tick = i_evt.tick;
                if (!i_state.mode_flag) begin
                    if (bri_clamped != i_state.brightness) begin
                        o_state.brightness = bri_clamped;
                        o_changed          = 1'b1;
                    end
                end else if (tmp_clamped != i_state.temperature) begin
                    o_state.temperature = tmp_clamped;
                    o_changed           = 1'b1;
                end
            end
            lpec_pkg::ACT_SWITCH: begin
                if (id_ok) begin
                    mask_req = (i_evt.value != 16'd0) ? (i_state.switches_on | id_bit)
                                                      : (i_state.switches_on & ~id_bit);
                    mask_do  = 1'b1;
                end
            end
            lpec_pkg::ACT_ONOFF: begin
                if (i_evt.value != 16'd0) begin
                    mask_req = restore_mask;
                end else begin
                    if (i_state.switches_on != '0) begin
                        o_state.last_active = i_state.switches_on;
                    end
                    mask_req = '0;
                end
                mask_do = 1'b1;
            end
            lpec_pkg::ACT_BRIGHT: begin
                if (bri_clamped != i_state.brightness) begin
                    o_state.brightness = bri_clamped;
                    o_changed          = 1'b1;
                end
            end
            lpec_pkg::ACT_TEMP: begin
                if (tmp_clamped != i_state.temperature) begin
                    o_state.temperature = tmp_clamped;
                    o_changed           = 1'b1;
                end
            end
            lpec_pkg::ACT_RS232: begin
                if ((i_evt.value != 16'd0) != i_state.serial_flag) begin
                    o_state.serial_flag = ~i_state.serial_flag;
                    o_changed           = 1'b1;
                end
            end
            lpec_pkg::ACT_OTA: begin
                if ((i_evt.value != 16'd0) != i_state.update_flag) begin
                    o_state.update_flag = ~i_state.update_flag;
                    o_changed           = 1'b1;
                end
            end
            default: begin
                o_changed = 1'b0;
            end
        endcase

        // Commit a new switch mask and remember it when non-empty
        if (mask_do && (mask_req != i_state.switches_on)) begin
            o_state.switches_on = mask_req;
            if (mask_req != '0) begin
                o_state.last_active = mask_req;
            end
            o_changed = 1'b1;
        end
    end

endmodule

FILE: sim/tb_light_panel_event_controller.sv
// Testbench for light_panel_event_controller: directed and random event streams,
// checked against a cycle-free model of the panel state kept in this file.
// Depends on lpec_pkg and the design sources only.
module tb_light_panel_event_controller;
    timeunit 1ns;
    timeprecision 1ps;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    lpec_pkg::t_in_item              i_in_data = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    lpec_pkg::t_out_item             o_out_data;
    logic                            i_cfg_we = 1'b0;
    logic [lpec_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [lpec_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    light_panel_event_controller dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Panel model: limits, committed state and the per-event changed flag
    lpec_pkg::t_cfg      limits;
    lpec_pkg::t_state    panel;
    bit                  touched;
    lpec_pkg::t_out_item panel_state_due[$];
    int                  fail_count = 0;
    bit                  calm = 1'b0;
    logic [31:0]         gen_tick = '0;

    function automatic void reset_panel();
        limits.blow   = lpec_pkg::RST_BLOW;
        limits.bhigh  = lpec_pkg::RST_BHIGH;
        limits.tlow   = lpec_pkg::RST_TLOW;
        limits.thigh  = lpec_pkg::RST_THIGH;
        limits.vfast  = lpec_pkg::RST_VFAST;
        limits.fast   = lpec_pkg::RST_FAST;
        limits.mid    = lpec_pkg::RST_MEDIUM;
        panel             = '0;
        panel.last_active = lpec_pkg::ALL_SWITCHES;
        panel.brightness  = lpec_pkg::RST_BHIGH;
        panel.temperature = lpec_pkg::RST_TLOW;
        panel_state_due.delete();
    endfunction

    function automatic void store_limit(logic [lpec_pkg::CFG_IDX_W-1:0] idx,
                                        logic [15:0] d);
        case (idx)
            lpec_pkg::CFG_BLOW:   limits.blow   = d[7:0];
            lpec_pkg::CFG_BHIGH:  limits.bhigh  = d[7:0];
            lpec_pkg::CFG_TLOW:   limits.tlow   = d;
            lpec_pkg::CFG_THIGH:  limits.thigh  = d;
            lpec_pkg::CFG_VFAST:  limits.vfast  = d;
            lpec_pkg::CFG_FAST:   limits.fast   = d;
            lpec_pkg::CFG_MEDIUM: limits.mid    = d;
            default: ;
        endcase
    endfunction

    // Low bound is checked first; when the bounds cross, a value below it gets the low bound, else the high
    function automatic int clamp_to(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void load_mask(logic [lpec_pkg::SWITCH_W-1:0] m);
        if (m == panel.switches_on) return;
        panel.switches_on = m;
        if (m != '0) panel.last_active = m;
        touched = 1'b1;
    endfunction

    function automatic void lights_off();
        if (panel.switches_on != '0) panel.last_active = panel.switches_on;
        load_mask('0);
    endfunction

    // An empty remembered mask brings every switch on
    function automatic void lights_back();
        logic [lpec_pkg::SWITCH_W-1:0] m;
        m = panel.last_active;
        if (m == '0) m = lpec_pkg::ALL_SWITCHES;
        load_mask(m);
    endfunction

    function automatic void apply_brightness(int v);
        logic [7:0] nb;
        nb = 8'(clamp_to(v, limits.blow, limits.bhigh));
        if (nb == panel.brightness) return;
        panel.brightness = nb;
        touched = 1'b1;
    endfunction

    function automatic void set_temperature(int v);
        logic [15:0] nt;
        nt = 16'(clamp_to(v, limits.tlow, limits.thigh));
        if (nt == panel.temperature) return;
        panel.temperature = nt;
        touched = 1'b1;
    endfunction

    // Elapsed ticks wrap modulo 2^32; the detent tick is kept in every mode
    function automatic lpec_pkg::t_speed detent_speed(logic [31:0] tk);
        logic [31:0] gap;
        gap = tk - panel.last_tick;
        panel.last_tick = tk;
        if (gap <= {16'd0, limits.vfast}) return lpec_pkg::SPD_VFAST;
        if (gap <= {16'd0, limits.fast})  return lpec_pkg::SPD_FAST;
        if (gap <= {16'd0, limits.mid})   return lpec_pkg::SPD_MED;
        return lpec_pkg::SPD_SLOW;
    endfunction

    function automatic lpec_pkg::t_out_item next_panel_state(lpec_pkg::t_in_item ev);
        lpec_pkg::t_out_item           r;
        logic [lpec_pkg::SWITCH_W-1:0] bitm;
        bit                            id_ok;
        int                            dir;
        int                            stride;
        lpec_pkg::t_speed              spd;
        touched = 1'b0;
        id_ok = (ev.target >= 1) && (ev.target <= lpec_pkg::SWITCH_COUNT);
        bitm = id_ok ? lpec_pkg::SWITCH_W'(1 << (ev.target - 1)) : '0;
        case (ev.action)
            lpec_pkg::ACT_BUTTON: begin
                if (id_ok) begin
                    load_mask(panel.switches_on ^ bitm);
                end else if (ev.target == lpec_pkg::BUTTON_ALL) begin
                    if (panel.switches_on != '0) lights_off();
                    else lights_back();
                end else if (ev.target == lpec_pkg::BUTTON_MODE) begin
                    panel.mode_flag = ~panel.mode_flag;
                end
            end
            lpec_pkg::ACT_CW, lpec_pkg::ACT_CCW: begin
                dir = (ev.action == lpec_pkg::ACT_CW) ? 1 : -1;
                spd = detent_speed(ev.tick);
                if (!panel.mode_flag) begin
                    case (spd)
                        lpec_pkg::SPD_VFAST: stride = 10;
                        lpec_pkg::SPD_FAST:  stride = 5;
                        lpec_pkg::SPD_MED:   stride = 2;
                        default:             stride = 1;
                    endcase
                    apply_brightness(int'(panel.brightness) + dir * stride);
                end else begin
                    case (spd)
                        lpec_pkg::SPD_VFAST: stride = 500;
                        lpec_pkg::SPD_FAST:  stride = 300;
                        lpec_pkg::SPD_MED:   stride = 200;
                        default:             stride = 100;
                    endcase
                    set_temperature(int'(panel.temperature) + dir * stride);
                end
            end
            lpec_pkg::ACT_SWITCH: begin
                if (id_ok) begin
                    load_mask((ev.value != 0) ? (panel.switches_on | bitm)
                                              : (panel.switches_on & ~bitm));
                end
            end
            lpec_pkg::ACT_ONOFF: begin
                if (ev.value != 0) lights_back();
                else lights_off();
            end
            lpec_pkg::ACT_BRIGHT: apply_brightness(int'(ev.value[7:0]));
            lpec_pkg::ACT_TEMP:   set_temperature(int'(ev.value));
            lpec_pkg::ACT_RS232: begin
                if (panel.serial_flag != (ev.value != 0)) begin
                    panel.serial_flag = ~panel.serial_flag;
                    touched = 1'b1;
                end
            end
            lpec_pkg::ACT_OTA: begin
                if (panel.update_flag != (ev.value != 0)) begin
                    panel.update_flag = ~panel.update_flag;
                    touched = 1'b1;
                end
            end
            default: ;
        endcase
        r.switch_mask    = panel.switches_on;
        r.light_on       = (panel.switches_on != '0);
        r.brightness_now = panel.brightness;
        r.temp_now       = panel.temperature;
        r.serial_enabled = panel.serial_flag;
        r.update_enabled = panel.update_flag;
        r.temp_mode      = panel.mode_flag;
        r.changed        = touched;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Track config writes, predict each accepted event, check each taken result
    always @(posedge i_clk) begin
        lpec_pkg::t_out_item want;
        if (!i_rst_n) begin
            reset_panel();
        end else begin
            if (i_cfg_we) store_limit(i_cfg_idx, i_cfg_data);
            if (o_out_valid && !i_out_stall) begin
                if (panel_state_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: result expected none, got %h", $time, o_out_data);
                end else begin
                    want = panel_state_due.pop_front();
                    check_field("switch_mask", want.switch_mask, o_out_data.switch_mask);
                    check_field("light_on", want.light_on, o_out_data.light_on);
                    check_field("brightness_now", want.brightness_now,
                                o_out_data.brightness_now);
                    check_field("temp_now", want.temp_now, o_out_data.temp_now);
                    check_field("serial_enabled", want.serial_enabled,
                                o_out_data.serial_enabled);
                    check_field("update_enabled", want.update_enabled,
                                o_out_data.update_enabled);
                    check_field("temp_mode", want.temp_mode, o_out_data.temp_mode);
                    check_field("changed", want.changed, o_out_data.changed);
                end
            end
            if (i_in_valid && !o_in_stall) panel_state_due.push_back(next_panel_state(i_in_data));
        end
    end

    // Result-side backpressure
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 21);
    end

    // Send one event; valid stays high unless an idle gap is taken
    task automatic send_event(input lpec_pkg::t_in_item ev);
        if (!calm) begin
            while ($urandom_range(0, 99) < 21) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Drop valid and wait until every result has been taken
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (panel_state_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [lpec_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
    endtask

    // Write all seven registers; unused upper bits of the byte registers get noise
    task automatic program_limits(input lpec_pkg::t_cfg c);
        write_reg(lpec_pkg::CFG_BLOW, {8'($urandom), c.blow});
        write_reg(lpec_pkg::CFG_BHIGH, {8'($urandom), c.bhigh});
        write_reg(lpec_pkg::CFG_TLOW, c.tlow);
        write_reg(lpec_pkg::CFG_THIGH, c.thigh);
        write_reg(lpec_pkg::CFG_VFAST, c.vfast);
        write_reg(lpec_pkg::CFG_FAST, c.fast);
        write_reg(lpec_pkg::CFG_MEDIUM, c.mid);
        i_cfg_we <= 1'b0;
    endtask

    function automatic lpec_pkg::t_in_item ev_of(logic [3:0] act, logic [7:0] id,
                                                 logic [15:0] val, logic [31:0] tk);
        lpec_pkg::t_in_item e;
        e.action = act;
        e.target = id;
        e.value  = val;
        e.tick   = tk;
        return e;
    endfunction

    function automatic logic [15:0] pick_limit(int lo, int hi, logic [15:0] top);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return top;
            default: return 16'($urandom_range(hi, lo));
        endcase
    endfunction

    function automatic lpec_pkg::t_cfg random_limits();
        lpec_pkg::t_cfg c;
        c.blow  = 8'(pick_limit(0, 60, 16'hFF));
        c.bhigh = 8'(pick_limit(40, 255, 16'hFF));
        c.tlow  = pick_limit(0, 5000, 16'hFFFF);
        c.thigh = pick_limit(3000, 65535, 16'hFFFF);
        c.vfast = pick_limit(0, 100, 16'hFFFF);
        c.fast  = pick_limit(50, 300, 16'hFFFF);
        c.mid   = pick_limit(200, 800, 16'hFFFF);
        return c;
    endfunction

    // Random event; detent ticks advance from the previous detent, often near a threshold
    function automatic lpec_pkg::t_in_item random_event();
        lpec_pkg::t_in_item e;
        int                 r;
        logic [31:0]        gap;
        logic [15:0]        thr;
        r = $urandom_range(0, 99);
        e.action = lpec_pkg::ACT_BUTTON;
        e.target = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, 9)) : 8'($urandom);
        e.value  = 16'($urandom);
        e.tick   = $urandom;
        if (r < 28) begin
            e.action = lpec_pkg::ACT_BUTTON;
        end else if (r < 58) begin
            e.action = ($urandom_range(0, 1) != 0) ? lpec_pkg::ACT_CW : lpec_pkg::ACT_CCW;
            case ($urandom_range(0, 5))
                0: gap = $urandom_range(0, 3);
                1: begin
                    case ($urandom_range(0, 2))
                        0:       thr = limits.vfast;
                        1:       thr = limits.fast;
                        default: thr = limits.mid;
                    endcase
                    gap = {16'd0, thr} + $urandom_range(0, 2) - 1;
                end
                2:       gap = $urandom_range(0, 400);
                3:       gap = $urandom;
                default: gap = $urandom_range(0, 100);
            endcase
            gen_tick = gen_tick + gap;
            e.tick = gen_tick;
        end else if (r < 66) begin
            e.action = lpec_pkg::ACT_SWITCH;
            if ($urandom_range(0, 1) != 0) e.value = '0;
        end else if (r < 72) begin
            e.action = lpec_pkg::ACT_ONOFF;
            if ($urandom_range(0, 1) != 0) e.value = '0;
        end else if (r < 80) begin
            e.action = lpec_pkg::ACT_BRIGHT;
            if ($urandom_range(0, 1) != 0)
                e.value[7:0] = (($urandom_range(0, 1) != 0) ? limits.blow : limits.bhigh)
                               + 8'($urandom_range(0, 2)) - 8'd1;
        end else if (r < 86) begin
            e.action = lpec_pkg::ACT_TEMP;
            if ($urandom_range(0, 1) != 0)
                e.value = (($urandom_range(0, 1) != 0) ? limits.tlow : limits.thigh)
                          + 16'($urandom_range(0, 2)) - 16'd1;
        end else if (r < 96) begin
            e.action = (r < 91) ? lpec_pkg::ACT_RS232 : lpec_pkg::ACT_OTA;
            if ($urandom_range(0, 1) != 0) e.value = '0;
        end else begin
            e.action = 4'($urandom_range(9, 15));
        end
        return e;
    endfunction

    // Every action, ignored ids, step thresholds, tick wrap and clamps at reset limits
    task automatic test_directed();
        send_event(ev_of(lpec_pkg::ACT_BUTTON, 8'd1, 16'd0, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_BUTTON, 8'd6, 16'd0, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_BUTTON, 8'd0, 16'd0, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_BUTTON, 8'd255, 16'd0, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_BUTTON, lpec_pkg::BUTTON_ALL, 16'd0, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_BUTTON, lpec_pkg::BUTTON_ALL, 16'd0, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_BUTTON, 8'd1, 16'd0, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_CW, 8'd0, 16'd0, 32'd60));
        send_event(ev_of(lpec_pkg::ACT_CCW, 8'd0, 16'd0, 32'd121));
        send_event(ev_of(lpec_pkg::ACT_CCW, 8'd0, 16'd0, 32'd251));
        send_event(ev_of(lpec_pkg::ACT_CCW, 8'd0, 16'd0, 32'd552));
        send_event(ev_of(lpec_pkg::ACT_CW, 8'd0, 16'd0, 32'd852));
        send_event(ev_of(lpec_pkg::ACT_BUTTON, lpec_pkg::BUTTON_MODE, 16'd0, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_CW, 8'd0, 16'd0, 32'hFFFF_FFF0));
        send_event(ev_of(lpec_pkg::ACT_CW, 8'd0, 16'd0, 32'h0000_0010));
        send_event(ev_of(lpec_pkg::ACT_CCW, 8'd0, 16'd0, 32'h0000_0010));
        send_event(ev_of(lpec_pkg::ACT_CCW, 8'd0, 16'd0, 32'h0000_0011));
        send_event(ev_of(lpec_pkg::ACT_SWITCH, 8'd0, 16'd1, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_SWITCH, 8'd7, 16'd1, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_SWITCH, 8'd3, 16'hFFFF, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_ONOFF, 8'd0, 16'd0, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_ONOFF, 8'd0, 16'h8000, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_BRIGHT, 8'd0, 16'hFF00, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_BRIGHT, 8'd0, 16'h00FF, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_TEMP, 8'd0, 16'd0, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_TEMP, 8'd0, 16'hFFFF, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_RS232, 8'd0, 16'h0100, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_OTA, 8'd0, 16'hFFFF, 32'd0));
        send_event(ev_of(4'd9, 8'd1, 16'hFFFF, 32'hFFFF_FFFF));
        send_event(ev_of(4'd15, 8'd7, 16'd1, 32'd0));
        wait_idle();
    endtask

    // Widest limits with every threshold at zero, then every threshold at its maximum
    task automatic test_extreme_limits();
        lpec_pkg::t_cfg c;
        c = '{blow: 8'd0, bhigh: 8'hFF, tlow: 16'd0, thigh: 16'hFFFF,
              vfast: 16'd0, fast: 16'd0, mid: 16'd0};
        program_limits(c);
        send_event(ev_of(lpec_pkg::ACT_TEMP, 8'd0, 16'd0, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_CCW, 8'd0, 16'd0, 32'd5));
        send_event(ev_of(lpec_pkg::ACT_TEMP, 8'd0, 16'hFFFF, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_CW, 8'd0, 16'd0, 32'd5));
        send_event(ev_of(lpec_pkg::ACT_BUTTON, lpec_pkg::BUTTON_MODE, 16'd0, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_BRIGHT, 8'd0, 16'd0, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_CCW, 8'd0, 16'd0, 32'd9));
        send_event(ev_of(lpec_pkg::ACT_BRIGHT, 8'd0, 16'd255, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_CW, 8'd0, 16'd0, 32'd9));
        wait_idle();
        c.vfast = 16'hFFFF;
        c.fast  = 16'hFFFF;
        c.mid   = 16'hFFFF;
        program_limits(c);
        send_event(ev_of(lpec_pkg::ACT_CCW, 8'd0, 16'd0, 32'd9 + 32'd65535));
        send_event(ev_of(lpec_pkg::ACT_CCW, 8'd0, 16'd0, 32'd9 + 32'd65535 + 32'd65536));
        send_event(ev_of(lpec_pkg::ACT_CW, 8'd0, 16'd0, 32'd0));
        wait_idle();
    endtask

    // Low bound above high bound on both levels
    task automatic test_inverted_limits();
        lpec_pkg::t_cfg c;
        c = '{blow: 8'd200, bhigh: 8'd50, tlow: 16'd6000, thigh: 16'd3000,
              vfast: lpec_pkg::RST_VFAST, fast: lpec_pkg::RST_FAST,
              mid: lpec_pkg::RST_MEDIUM};
        program_limits(c);
        send_event(ev_of(lpec_pkg::ACT_BRIGHT, 8'd0, 16'd100, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_BRIGHT, 8'd0, 16'd255, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_CW, 8'd0, 16'd0, 32'd1000));
        send_event(ev_of(lpec_pkg::ACT_TEMP, 8'd0, 16'd4000, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_TEMP, 8'd0, 16'd7000, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_BUTTON, lpec_pkg::BUTTON_MODE, 16'd0, 32'd0));
        send_event(ev_of(lpec_pkg::ACT_CCW, 8'd0, 16'd0, 32'd1001));
        send_event(ev_of(lpec_pkg::ACT_BUTTON, lpec_pkg::BUTTON_MODE, 16'd0, 32'd0));
        wait_idle();
    endtask

    // Random limits and a random event stream; a quiet phase runs with no idling
    task automatic test_random_traffic(input int count, input bit quiet);
        program_limits(random_limits());
        gen_tick = panel.last_tick;
        calm = quiet;
        repeat (count) send_event(random_event());
        wait_idle();
        calm = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_extreme_limits();
        test_inverted_limits();
        for (int p = 0; p < 6; p++) test_random_traffic(280, p == 2);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #400000;
        $display("FAIL");
        $finish;
    end

endmodule
